@@ sv/gda_pkg.sv @@
// Package for the Gregorian date-plus-days block.
// Holds field widths, calendar constants, word and control types, and the month length function.
// No dependencies.
`default_nettype none

package gda_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int OFFSET_W = 20;

  localparam int OFFSET_BITS_DEF = 20;

  localparam int CYCLE_DAYS  = 146097;
  localparam int CYCLE_YEARS = 400;
  localparam int YEAR_MAX    = 16383;
  localparam int DAY_MAX     = 31;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0]   start_year;
    logic [MONTH_W-1:0]  start_month;
    logic [DAY_W-1:0]    start_day;
    logic [OFFSET_W-1:0] day_offset;
  } in_word_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  result_year;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;
    logic               year_overflow;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic cyc_step;
    logic mon_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic rem_gt_cycle;
    logic rem_gt_month;
    logic year_ovf;
  } status_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ sv/gregorian_date_add_days_core.sv @@
// Gregorian date plus days: one result word per input word. After a word is taken the block
// reduces the year modulo 400 by repeated subtraction, then skips whole 400-year spans
// (146097 days each, at most seven for a 20-bit offset), then walks the remaining days month by
// month. The skips leave at most 146097 days for the month walk. A finished result waits until
// the output register is free (not holding a stalled result) before it is loaded. One word is
// worked at a time; the next word is taken while a finished result waits in the output register.
// Depends on gda_pkg, gda_ctrl, gda_dpath.
`default_nettype none

module gregorian_date_add_days_core
  import gda_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  cmd_t    cmd;
  status_t status;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gda_dpath #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .status   (status),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

@@ sv/gda_dpath.sv @@
// Datapath of the date-plus-days block: year, year-mod-400, month and remaining-day registers.
// Executes one controller command per cycle and reports status. Depends on gda_pkg.
`default_nettype none

module gda_dpath
  import gda_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  cmd_t      cmd,
  output status_t   status,
  output out_word_t out_word
);

  localparam int OFF_USED = (OFFSET_BITS < OFFSET_W) ? OFFSET_BITS : OFFSET_W;
  localparam int REM_W    = OFF_USED + 1;
  localparam int CYC_W    = $clog2(CYCLE_DAYS + 1);
  localparam int CMP_W    = (REM_W > CYC_W) ? REM_W : CYC_W;

  // year_r carries one extra bit so that passing the largest year is visible.
  logic [YEAR_W:0]      year_r, year_nxt;
  logic [YEAR_W-1:0]    ymod_r, ymod_nxt;
  logic [MONTH_W-1:0]   month_r, month_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  out_word_t            out_r, out_nxt;

  logic                 leap;
  logic [DAY_W-1:0]     mdays;
  logic [REM_W-1:0]     mdays_ext;
  logic [CMP_W-1:0]     rem_ext;
  logic [MONTH_W-1:0]   month_in;

  // After the reduction pass ymod_r holds the year modulo 400, so a century year
  // that is not a multiple of 400 shows up as 100, 200 or 300.
  assign leap = (year_r[1:0] == 2'b00) &&
                !((ymod_r == YEAR_W'(100)) || (ymod_r == YEAR_W'(200)) ||
                  (ymod_r == YEAR_W'(300)));
  assign mdays     = month_len(month_r, leap);
  assign mdays_ext = REM_W'(mdays);
  assign rem_ext   = CMP_W'(rem_r);

  always_comb begin
    if (in_word.start_month == '0) begin
      month_in = MONTH_JAN;
    end else if (in_word.start_month > MONTH_DEC) begin
      month_in = MONTH_DEC;
    end else begin
      month_in = in_word.start_month;
    end
  end

  always_comb begin
    year_nxt  = year_r;
    ymod_nxt  = ymod_r;
    month_nxt = month_r;
    rem_nxt   = rem_r;
    out_nxt   = out_r;
    if (cmd.load) begin
      year_nxt  = {1'b0, in_word.start_year};
      ymod_nxt  = in_word.start_year;
      month_nxt = month_in;
      rem_nxt   = REM_W'(in_word.start_day) + REM_W'(in_word.day_offset[OFF_USED-1:0]);
    end
    if (cmd.mod_step) begin
      ymod_nxt = ymod_r - YEAR_W'(CYCLE_YEARS);
    end
    if (cmd.cyc_step) begin
      rem_nxt  = REM_W'(rem_ext - CMP_W'(CYCLE_DAYS));
      year_nxt = year_r + (YEAR_W + 1)'(CYCLE_YEARS);
    end
    if (cmd.mon_step) begin
      rem_nxt = rem_r - mdays_ext;
      if (month_r == MONTH_DEC) begin
        month_nxt = MONTH_JAN;
        year_nxt  = year_r + 1'b1;
        ymod_nxt  = (ymod_r == YEAR_W'(CYCLE_YEARS - 1)) ? '0 : ymod_r + 1'b1;
      end else begin
        month_nxt = month_r + 1'b1;
      end
    end
    if (cmd.out_load) begin
      if (year_r[YEAR_W]) begin
        out_nxt.result_year   = YEAR_W'(YEAR_MAX);
        out_nxt.result_month  = MONTH_DEC;
        out_nxt.result_day    = DAY_W'(DAY_MAX);
        out_nxt.year_overflow = 1'b1;
      end else begin
        out_nxt.result_year   = year_r[YEAR_W-1:0];
        out_nxt.result_month  = month_r;
        out_nxt.result_day    = rem_r[DAY_W-1:0];
        out_nxt.year_overflow = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    year_r  <= year_nxt;
    ymod_r  <= ymod_nxt;
    month_r <= month_nxt;
    rem_r   <= rem_nxt;
    out_r   <= out_nxt;
  end

  assign status.mod_done     = ymod_r < YEAR_W'(CYCLE_YEARS);
  assign status.rem_gt_cycle = rem_ext > CMP_W'(CYCLE_DAYS);
  assign status.rem_gt_month = rem_r > mdays_ext;
  assign status.year_ovf     = year_r[YEAR_W];
  assign out_word            = out_r;

`ifndef SYNTHESIS
  a_day_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && !year_r[YEAR_W] |-> rem_r <= REM_W'(DAY_MAX))
    else $error("result day does not fit the month");
  a_mod_before_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cyc_step || cmd.mon_step |-> ymod_r < YEAR_W'(CYCLE_YEARS))
    else $error("year walk started before the modulo pass finished");
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mon_step |-> month_r >= MONTH_JAN && month_r <= MONTH_DEC)
    else $error("month register out of range");
`endif

endmodule

`default_nettype wire

@@ sv/gda_ctrl.sv @@
// Controller of the date-plus-days block: sequences the modulo pass, the 400-year skips
// and the month walk, and owns both handshakes. Depends on gda_pkg.
`default_nettype none

module gda_ctrl
  import gda_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD  = 3'd1;
  localparam logic [2:0] ST_CYC  = 3'd2;
  localparam logic [2:0] ST_MON  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (status.mod_done) begin
          state_nxt = ST_CYC;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      ST_CYC: begin
        if (status.year_ovf) begin
          state_nxt = ST_DONE;
        end else if (status.rem_gt_cycle) begin
          cmd.cyc_step = 1'b1;
        end else begin
          state_nxt = ST_MON;
        end
      end
      ST_MON: begin
        if (status.year_ovf || !status.rem_gt_month) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.mon_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.mod_step, cmd.cyc_step, cmd.mon_step, cmd.out_load}))
    else $error("more than one datapath command in a cycle");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_MOD)
    else $error("accepted word did not start the modulo pass");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire
